### rtl/rrb_pkg.sv
package rrb_pkg;

	typedef struct packed {
		logic [5:0]  source_index;
		logic [31:0] wrap_cycles;
		logic [15:0] max_seq;
		logic [31:0] base_seq;
		logic [31:0] packets_received;
		logic        sr_seen;
		logic [63:0] sr_ntp;
		logic [31:0] now_sec;
		logic [19:0] now_usec;
		logic [31:0] sr_arrival_sec;
		logic [19:0] sr_arrival_usec;
	} req_t;

	typedef struct packed {
		logic [31:0] ext_highest_seq;
		logic [23:0] cumulative_lost;
		logic [7:0]  fraction_lost;
		logic [31:0] last_sr;
		logic [31:0] delay_since_sr;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RM_ZERO,
		RM_SAT,
		RM_DIV
	} res_mode_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
	// 65536 / 1000000 reduces to 1024 / 15625
	localparam int unsigned DLY_SHIFT    = 10;
	localparam logic [13:0] DLY_DIV      = 14'd15625;
	// delays of 65536 s or more saturate
	localparam logic [53:0] DLY_LIMIT    = 54'd65536 * 54'(USEC_PER_SEC);
	localparam int unsigned DLY_NUM_W    = 46;
	localparam int unsigned DLY_STEPS    = 11;
	localparam int unsigned FRAC_STEPS   = 8;
	localparam int unsigned CNT_W        = 4;
	localparam logic [7:0]  FRAC_SAT     = 8'd255;
	localparam logic [31:0] DLY_SAT      = 32'hFFFF_FFFF;

endpackage

### rtl/rtcp_receiver_report_block_unit.sv
// Channel | Direction | Handshake                  | Payload
// req     | in        | req_valid / req_stall      | rrb_pkg::req_t, one per report
// rsp     | out       | rsp_valid / rsp_stall      | rrb_pkg::rsp_t, one per request
//
// Between one acceptance and the next possible one a request passes a prior-count
// read, one prepare step and 11 radix-8 steps of the delay divider (the fraction
// divider finishes its 8 steps alongside) and the result load, held on a stall.
// After reset the prior-count memory is zeroed, one entry per cycle, through all
// SOURCE_COUNT entries; req_stall stays high meanwhile.
// A waiting result sits in the output register; the next request is still taken.
module rtcp_receiver_report_block_unit #(
	parameter int unsigned SOURCE_COUNT = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rrb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rrb_pkg::rsp_t rsp
);
	import rrb_pkg::*;

	localparam int unsigned IDX_W = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	req_t             req_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      ext_q;
	logic [31:0]      expected_q;
	logic [31:0]      exp_int_q;
	logic [31:0]      lost_int_q;
	logic [23:0]      cum_lost_q;
	logic [51:0]      prod_q;
	logic signed [20:0] dus_q;
	res_mode_t        frac_mode_q;
	res_mode_t        dly_mode_q;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [63:0]      mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	logic [63:0]      mem_rdata;

	div_ctl_t         frac_ctl;
	div_ctl_t         dly_ctl;
	logic             load_rsp;

	logic [31:0]      exp_int;
	logic [31:0]      lost_int;
	logic [31:0]      dsec;
	logic signed [53:0] tot;
	logic [DLY_NUM_W-1:0] dly_num;
	logic [7:0]       frac_quot;
	logic [31:0]      dly_quot;
	logic [7:0]       frac_res;
	logic [31:0]      dly_res;

	// index modulo the source count by conditional subtraction
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [5:0] s);
		logic [17:0] r;
		r = 18'(s);
		for (int k = 5; k >= 0; k--) begin
			if (r >= (18'(SOURCE_COUNT) << k)) begin
				r = r - (18'(SOURCE_COUNT) << k);
			end
		end
		return r[IDX_W-1:0];
	endfunction

	rrb_mem #(
		.DEPTH(SOURCE_COUNT),
		.AW   (IDX_W),
		.DW   (64)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	rrb_frac_div u_frac (
		.clk       (clk),
		.ctl       (frac_ctl),
		.lost      (lost_int_q),
		.expect_cnt(exp_int_q),
		.quot      (frac_quot)
	);

	rrb_dly_div u_dly (
		.clk (clk),
		.ctl (dly_ctl),
		.num (dly_num),
		.quot(dly_quot)
	);

	assign mem_raddr = wrap_idx(req.source_index);

	// prior counts: expected in the upper half, received in the lower
	assign exp_int  = expected_q - mem_rdata[63:32];
	assign lost_int = exp_int - (req_q.packets_received - mem_rdata[31:0]);

	// seconds difference wraps at 32 bits
	assign dsec = req_q.now_sec - req_q.sr_arrival_sec;

	assign tot     = $signed({2'b00, prod_q}) + 54'(dus_q);
	assign dly_num = {tot[DLY_NUM_W-DLY_SHIFT-1:0], DLY_SHIFT'(0)};

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		frac_ctl  = '0;
		dly_ctl   = '0;
		load_rsp  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == IDX_W'(SOURCE_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					mem_re  = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = {expected_q, req_q.packets_received};
				state_d   = ST_PREP;
			end
			ST_PREP: begin
				frac_ctl.load = 1'b1;
				dly_ctl.load  = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				dly_ctl.step  = 1'b1;
				frac_ctl.step = cnt_q < CNT_W'(FRAC_STEPS);
				if (cnt_q == CNT_W'(DLY_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_PREP) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		unique case (frac_mode_q)
			RM_ZERO: frac_res = '0;
			RM_SAT:  frac_res = FRAC_SAT;
			RM_DIV:  frac_res = frac_quot;
			default: frac_res = '0;
		endcase
		unique case (dly_mode_q)
			RM_ZERO: dly_res = '0;
			RM_SAT:  dly_res = DLY_SAT;
			RM_DIV:  dly_res = dly_quot;
			default: dly_res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q      <= req;
			idx_q      <= mem_raddr;
			ext_q      <= req.wrap_cycles + 32'(req.max_seq);
			expected_q <= req.wrap_cycles + 32'(req.max_seq) - req.base_seq;
		end
		if (state_q == ST_READ) begin
			exp_int_q  <= exp_int;
			lost_int_q <= lost_int;
			cum_lost_q <= 24'(expected_q - req_q.packets_received);
			prod_q     <= 52'(dsec) * 52'(USEC_PER_SEC);
			dus_q      <= $signed({1'b0, req_q.now_usec}) -
				$signed({1'b0, req_q.sr_arrival_usec});
		end
		if (state_q == ST_PREP) begin
			// repair, nothing lost or no progress gives zero; all lost and worse saturate
			priority if (exp_int_q == '0 || lost_int_q == '0 || lost_int_q[31]) begin
				frac_mode_q <= RM_ZERO;
			end else if (lost_int_q >= exp_int_q) begin
				frac_mode_q <= RM_SAT;
			end else begin
				frac_mode_q <= RM_DIV;
			end
			priority if (!req_q.sr_seen || tot[53] || tot == '0) begin
				dly_mode_q <= RM_ZERO;
			end else if ($unsigned(tot) >= DLY_LIMIT) begin
				dly_mode_q <= RM_SAT;
			end else begin
				dly_mode_q <= RM_DIV;
			end
		end
		if (load_rsp) begin
			rsp_q.ext_highest_seq <= ext_q;
			rsp_q.cumulative_lost <= cum_lost_q;
			rsp_q.fraction_lost   <= frac_res;
			rsp_q.last_sr         <= req_q.sr_seen ? req_q.sr_ntp[47:16] : '0;
			rsp_q.delay_since_sr  <= dly_res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/rrb_mem.sv
module rrb_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6,
	parameter int unsigned DW    = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/rrb_frac_div.sv
module rrb_frac_div (
	input  logic                clk,
	input  rrb_pkg::div_ctl_t   ctl,
	input  logic [31:0]         lost,
	input  logic [31:0]         expect_cnt,
	output logic [7:0]          quot
);
	import rrb_pkg::*;

	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic [7:0]  quot_q;
	logic [32:0] trial;
	logic        fits;

	// restoring divide, one quotient bit per step; lost < expected on entry
	assign trial = {rem_q, 1'b0};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q  <= lost;
			div_q  <= expect_cnt;
			quot_q <= '0;
		end else if (ctl.step) begin
			rem_q  <= fits ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			quot_q <= {quot_q[6:0], fits};
		end
	end

	assign quot = quot_q;

endmodule

### rtl/rrb_dly_div.sv
module rrb_dly_div (
	input  logic                           clk,
	input  rrb_pkg::div_ctl_t              ctl,
	input  logic [rrb_pkg::DLY_NUM_W-1:0]  num,
	output logic [31:0]                    quot
);
	import rrb_pkg::*;

	// radix-8 long division by the constant; remainder stays below the divisor
	localparam int unsigned LOW_W = 3 * DLY_STEPS;

	logic [13:0]      rem_q;
	logic [LOW_W-1:0] num_q;
	logic [31:0]      quot_q;
	logic [16:0]      trial;
	logic [2:0]       digit;
	logic [16:0]      sub;

	function automatic logic [16:0] multiple(input logic [2:0] k);
		return 17'(k) * 17'(DLY_DIV);
	endfunction

	assign trial = {rem_q, num_q[LOW_W-1 -: 3]};

	always_comb begin
		digit = '0;
		for (int k = 1; k < 8; k++) begin
			if (trial >= multiple(3'(k))) begin
				digit = 3'(k);
			end
		end
		sub = trial - multiple(digit);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q  <= 14'(num[DLY_NUM_W-1:LOW_W]);
			num_q  <= num[LOW_W-1:0];
			quot_q <= '0;
		end else if (ctl.step) begin
			rem_q  <= sub[13:0];
			num_q  <= {num_q[LOW_W-4:0], 3'b000};
			quot_q <= {quot_q[28:0], digit};
		end
	end

	assign quot = quot_q;

endmodule

### rtl/rrb_checker.sv
module rrb_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input rrb_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input rrb_pkg::rsp_t rsp
);
	import rrb_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed or dropped");

	// one request at a time: busy right after acceptance
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one in flight");

	// a result does not rise during the read and prepare states of its request
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
		else $error("result appeared too early");

	// a new result is only loaded at the end of a busy period
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared while idle");

endmodule

bind rtcp_receiver_report_block_unit rrb_checker u_rrb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

### verif/tb_top.sv
module tb_top;
	import rrb_pkg::*;

	localparam int SOURCES = 64;
	localparam int RANDOM_ITEMS = 1850;
	localparam int CALM_ITEMS = 250;
	localparam int CYCLE_LIMIT = 400000;
	localparam longint USEC = 1000000;
	localparam longint DELAY_CAP = 65536 * USEC;

	class report_board;
		bit [31:0] last_expected[SOURCES];
		bit [31:0] last_received[SOURCES];
		rsp_t pending_reports[$];
		int errors;

		function bit [7:0] lost_fraction(bit [31:0] exp_int, bit [31:0] lost_int);
			bit [63:0] q;
			// nothing expected, nothing lost, or a repair
			if (exp_int == 0 || lost_int == 0 || lost_int[31])
				return 8'd0;
			q = {24'b0, lost_int, 8'b0} / {32'b0, exp_int};
			return (q > 255) ? 8'hFF : q[7:0];
		endfunction

		function bit [31:0] sr_delay_units(bit [31:0] now_s, bit [19:0] now_us,
				bit [31:0] arr_s, bit [19:0] arr_us);
			bit [31:0] secs;
			longint total;
			secs = now_s - arr_s;
			total = {32'b0, secs} * USEC + {44'b0, now_us} - {44'b0, arr_us};
			if (total <= 0)
				return 32'd0;
			if (total >= DELAY_CAP)
				return 32'hFFFF_FFFF;
			return 32'((total * 65536) / USEC);
		endfunction

		function void note_request(req_t r);
			bit [31:0] ext, expected, exp_int, rcv_int;
			rsp_t o;
			ext = r.wrap_cycles + 32'(r.max_seq);
			expected = ext - r.base_seq;
			exp_int = expected - last_expected[r.source_index];
			rcv_int = r.packets_received - last_received[r.source_index];
			last_expected[r.source_index] = expected;
			last_received[r.source_index] = r.packets_received;
			o = '0;
			o.ext_highest_seq = ext;
			o.cumulative_lost = 24'(expected - r.packets_received);
			o.fraction_lost = lost_fraction(exp_int, exp_int - rcv_int);
			if (r.sr_seen) begin
				o.last_sr = r.sr_ntp[47:16];
				o.delay_since_sr = sr_delay_units(r.now_sec, r.now_usec,
					r.sr_arrival_sec, r.sr_arrival_usec);
			end
			pending_reports.push_back(o);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			if (pending_reports.size() == 0) begin
				report($sformatf("result %h with no request pending", got));
				return;
			end
			want = pending_reports.pop_front();
			if (got.ext_highest_seq !== want.ext_highest_seq)
				report($sformatf("ext_highest_seq got %h want %h",
					got.ext_highest_seq, want.ext_highest_seq));
			if (got.cumulative_lost !== want.cumulative_lost)
				report($sformatf("cumulative_lost got %h want %h",
					got.cumulative_lost, want.cumulative_lost));
			if (got.fraction_lost !== want.fraction_lost)
				report($sformatf("fraction_lost got %h want %h",
					got.fraction_lost, want.fraction_lost));
			if (got.last_sr !== want.last_sr)
				report($sformatf("last_sr got %h want %h", got.last_sr, want.last_sr));
			if (got.delay_since_sr !== want.delay_since_sr)
				report($sformatf("delay_since_sr got %h want %h",
					got.delay_since_sr, want.delay_since_sr));
		endtask

		function int pending();
			return pending_reports.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	report_board board;
	bit calm;
	int cycle_count = 0;

	rtcp_receiver_report_block_unit #(.SOURCE_COUNT(SOURCES)) dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_result(rsp);
	end

	// receiver back-pressure in bursts, none once the run goes calm
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	function req_t counts_req(bit [5:0] src, bit [31:0] base, bit [31:0] ext,
			bit [31:0] recv);
		req_t r;
		r = '0;
		r.source_index = src;
		r.wrap_cycles = {ext[31:16], 16'b0};
		r.max_seq = ext[15:0];
		r.base_seq = base;
		r.packets_received = recv;
		return r;
	endfunction

	function req_t sr_fields(req_t r, bit seen, bit [31:0] now_s, bit [19:0] now_us,
			bit [31:0] arr_s, bit [19:0] arr_us);
		r.sr_seen = seen;
		r.sr_ntp = {$urandom, $urandom};
		r.now_sec = now_s;
		r.now_usec = now_us;
		r.sr_arrival_sec = arr_s;
		r.sr_arrival_usec = arr_us;
		return r;
	endfunction

	task automatic send_request(input req_t r);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		board.note_request(r);
		if (!calm && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	initial begin
		req_t r;
		bit [31:0] flow_ext[SOURCES];
		bit [31:0] flow_base[SOURCES];
		bit [31:0] flow_recv[SOURCES];
		int unsigned src, step, got, kind;
		bit [31:0] arr_s, now_s;
		bit [19:0] now_us, arr_us;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		calm = 1'b0;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes and the corner cases of loss and delay
		send_request(counts_req(6'd0, 32'd0, 32'd0, 32'd0));
		r = '1;
		send_request(r);
		send_request(counts_req(6'd1, 32'd0, 32'd100, 32'd0));     // all lost
		send_request(counts_req(6'd1, 32'd0, 32'd200, 32'd150));   // repair
		send_request(counts_req(6'd1, 32'd0, 32'd300, 32'd200));   // half lost
		send_request(counts_req(6'd1, 32'd0, 32'd300, 32'd200));   // no progress
		send_request(counts_req(6'd2, 32'hFFFF_FFF0, 32'h30, 32'd64));
		send_request(counts_req(6'd3, 32'd1000, 32'd1010, 32'd20));
		send_request(counts_req(6'd62, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));
		send_request(sr_fields(counts_req(6'd4, 0, 10, 9), 1'b1, 10, 100, 9, 999900));
		send_request(sr_fields(counts_req(6'd5, 0, 10, 9), 1'b1, 5, 10, 5, 20));
		send_request(sr_fields(counts_req(6'd6, 0, 10, 9), 1'b1, 0, 0, 1, 0));
		send_request(sr_fields(counts_req(6'd7, 0, 10, 9), 1'b1, 65542, 999999, 7, 0));
		send_request(sr_fields(counts_req(6'd8, 0, 10, 9), 1'b1, 65543, 0, 7, 0));
		send_request(sr_fields(counts_req(6'd9, 0, 10, 9), 1'b1, 3, 20'hFFFFF, 3, 0));
		send_request(sr_fields(counts_req(6'd10, 0, 10, 9), 1'b0, 100, 5, 1, 7));
		send_request(sr_fields(counts_req(6'd11, 0, 10, 9), 1'b1, 42, 500, 42, 500));
		r = sr_fields(counts_req(6'd12, 0, 10, 9), 1'b1, 9, 0, 8, 0);
		r.sr_ntp = 64'h0123_4567_89AB_CDEF;
		send_request(r);

		for (int s = 0; s < SOURCES; s++) begin
			flow_base[s] = $urandom;
			flow_ext[s] = flow_base[s] + $urandom_range(0, 1000);
			flow_recv[s] = $urandom_range(0, 1000);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
			if ($urandom_range(0, 4) == 0) begin
				r.source_index = 6'($urandom);
				r.wrap_cycles = $urandom_range(0, 32'hFFFF_0000);
				r.max_seq = 16'($urandom);
				r.base_seq = $urandom;
				r.packets_received = $urandom;
				r.sr_seen = 1'($urandom);
				r.sr_ntp = {$urandom, $urandom};
				r.now_sec = $urandom;
				r.now_usec = 20'($urandom);
				r.sr_arrival_sec = $urandom;
				r.sr_arrival_usec = 20'($urandom);
			end else begin
				// a source advancing from report to report
				src = $urandom_range(0, SOURCES - 1);
				step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70000)
					: $urandom_range(0, 300);
				case ($urandom_range(0, 9))
					0: got = 0;
					1: got = step + $urandom_range(1, 50);
					2: got = step;
					default: got = step - $urandom_range(0, step / 4);
				endcase
				flow_ext[src] += step;
				flow_recv[src] += got;
				arr_s = $urandom;
				kind = $urandom_range(0, 9);
				case (kind)
					7: now_s = arr_s + $urandom_range(65530, 65540);
					8: now_s = $urandom;
					9: now_s = arr_s;
					default: now_s = arr_s + $urandom_range(0, 30);
				endcase
				now_us = ($urandom_range(0, 19) == 0) ? 20'($urandom)
					: 20'($urandom_range(0, 999999));
				arr_us = ($urandom_range(0, 19) == 0) ? 20'($urandom)
					: 20'($urandom_range(0, 999999));
				r = sr_fields(counts_req(6'(src), flow_base[src], flow_ext[src],
					flow_recv[src]), $urandom_range(0, 4) != 0, now_s, now_us,
					arr_s, arr_us);
			end
			send_request(r);
		end
		req_valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
